@@ sv/idl_byte_tokenizer_core_defines.svh @@
// Assertion macros for the tokenizer checker.
// Needs nothing else; included by files that hold assertions.
`ifndef IDL_BYTE_TOKENIZER_CORE_DEFINES_SVH
`define IDL_BYTE_TOKENIZER_CORE_DEFINES_SVH

// clocked assertion, off while reset is high
`define IBT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define IBT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ibt_pkg.sv @@
// Shared types, codes and keyword tables of the byte tokenizer.
// No dependencies.
package ibt_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_SLASH   = 3'd3,
    MODE_COMMENT = 3'd4
  } scan_mode_t;

  localparam logic [3:0] KIND_KEYWORD  = 4'd0;
  localparam logic [3:0] KIND_IDENT    = 4'd1;
  localparam logic [3:0] KIND_NUMBER   = 4'd2;
  localparam logic [3:0] KIND_EOF      = 4'd3;
  localparam logic [3:0] KIND_ERROR    = 4'd4;
  localparam logic [3:0] KIND_PLUS     = 4'd5;
  localparam logic [3:0] KIND_MINUS    = 4'd6;
  localparam logic [3:0] KIND_LPAREN   = 4'd7;
  localparam logic [3:0] KIND_RPAREN   = 4'd8;
  localparam logic [3:0] KIND_LBRACE   = 4'd9;
  localparam logic [3:0] KIND_RBRACE   = 4'd10;
  localparam logic [3:0] KIND_LBRACKET = 4'd11;
  localparam logic [3:0] KIND_RBRACKET = 4'd12;
  localparam logic [3:0] KIND_COMMA    = 4'd13;
  localparam logic [3:0] KIND_SEMI     = 4'd14;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  localparam int NUM_KW = 5;
  localparam logic [15:0] KW_LEN [NUM_KW] = '{16'd7, 16'd3, 16'd7, 16'd5, 16'd4};
  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"s", "e", "r", "v", "i", "c", "e", 8'h00},
    '{"r", "p", "c", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", "s", 8'h00},
    '{"i", "n", "t", "3", "2", 8'h00, 8'h00, 8'h00},
    '{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic        last;
    logic [15:0] line;
    logic [15:0] length;
    logic [15:0] offset;
    logic [3:0]  kind;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } step_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [15:0] sat16_inc(input logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

  // drop every keyword that has no character at position len or whose character there differs from c
  function automatic logic [4:0] kw_match(input logic [4:0] hits, input logic [15:0] len,
                                          input logic [7:0] c);
    logic [4:0] r;
    r = hits;
    for (int k = 0; k < NUM_KW; k++) begin
      if (len >= KW_LEN[k] || KW_TEXT[k][len[2:0]] != c) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [3:0] ident_kind(input logic [4:0] hits, input logic [15:0] len);
    logic kw;
    kw = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (hits[k] && len == KW_LEN[k]) kw = 1'b1;
    end
    return kw ? KIND_KEYWORD : KIND_IDENT;
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] r;
    unique case (c)
      "+":     r = KIND_PLUS;
      "-":     r = KIND_MINUS;
      "(":     r = KIND_LPAREN;
      ")":     r = KIND_RPAREN;
      "{":     r = KIND_LBRACE;
      "}":     r = KIND_RBRACE;
      "[":     r = KIND_LBRACKET;
      "]":     r = KIND_RBRACKET;
      ",":     r = KIND_COMMA;
      ";":     r = KIND_SEMI;
      default: r = KIND_ERROR;
    endcase
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    logic r;
    case (c) inside
      CH_SPACE, CH_TAB, CH_CR: r = 1'b1;
      default:                 r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/idl_byte_tokenizer_core.sv @@
// Top level of the byte tokenizer: scanner plus output token queue.
// Depends on ibt_pkg, ibt_lexer and ibt_token_fifo.
//
// Source bytes enter on the s_* channel, one item per byte; byte 0 ends the
// source and yields an EOF token, after which the scanner starts over.
// Tokens leave on the m_* channel; m_tlast marks the last token produced by
// one input byte. A byte yields zero, one or two tokens.
// A token is written into the queue when the byte that finishes it is
// accepted, and is offered on m_* once the tokens ahead of it are taken.
// Throughput: one byte per cycle while s_tready is high. The scanner
// decides all tokens of a byte combinationally and writes them into a
// four-entry queue; s_tready is high while at least two entries are free,
// so a byte that closes one token and starts another finds room for both.
// When the receiver stalls, the queue fills and s_tready falls; the token
// on m_* holds until taken. Reset (rst, synchronous) empties the queue and
// returns the scanner to idle at offset 0, line 1.
module idl_byte_tokenizer_core #(
  parameter int MAX_SOURCE_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] source_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [3:0] kind, [19:4] offset, [35:20] length, [51:36] line
  output logic        m_tlast
);

  ibt_pkg::step_t  step;
  ibt_pkg::token_t tok;
  logic            in_fire;

  assign in_fire = s_tvalid && s_tready;

  ibt_lexer #(.MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)) u_lexer (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .in_byte (s_tdata),
    .step    (step)
  );

  ibt_token_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_fire),
    .wr_step  (step),
    .room     (s_tready),
    .rd_en    (m_tready),
    .rd_valid (m_tvalid),
    .rd_tok   (tok)
  );

  assign m_tdata = {4'b0000, tok.line, tok.length, tok.offset, tok.kind};
  assign m_tlast = tok.last;

endmodule

@@ sv/ibt_lexer.sv @@
// Scanner state and per-byte token decode of the tokenizer.
// Depends on ibt_pkg.
module ibt_lexer #(
  parameter int MAX_SOURCE_BYTES = 65536
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic [7:0]     in_byte,
  output ibt_pkg::step_t step
);

  localparam int POS_LIMIT = (MAX_SOURCE_BYTES - 1 > 65535) ? 65535 : MAX_SOURCE_BYTES - 1;
  localparam logic [15:0] POS_LIM = POS_LIMIT[15:0];

  ibt_pkg::scan_mode_t mode, mode_next;
  logic [15:0] pos, pos_next;
  logic [15:0] pstart, pstart_next;
  logic [15:0] plen, plen_next;
  logic [15:0] line, line_next;
  logic [4:0]  hits, hits_next;

  logic        c_alpha, c_digit, c_ident, c_blank, go_idle;
  logic [15:0] pos_inc;

  assign c_alpha = ibt_pkg::is_alpha(in_byte);
  assign c_digit = ibt_pkg::is_digit(in_byte);
  assign c_ident = c_alpha || c_digit || in_byte == ibt_pkg::CH_UNDER;
  assign c_blank = ibt_pkg::is_blank(in_byte);
  assign pos_inc = (pos < POS_LIM) ? pos + 16'd1 : POS_LIM;

  always_comb begin
    unique case (mode)
      ibt_pkg::MODE_IDENT:   go_idle = !c_ident;
      ibt_pkg::MODE_NUMBER:  go_idle = !c_digit;
      ibt_pkg::MODE_SLASH:   go_idle = in_byte != ibt_pkg::CH_SLASH;
      ibt_pkg::MODE_COMMENT: go_idle = in_byte == ibt_pkg::CH_NUL || in_byte == ibt_pkg::CH_NL;
      default:               go_idle = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    pstart_next = pstart;
    plen_next   = plen;
    line_next   = line;
    hits_next   = hits;
    unique case (mode)
      ibt_pkg::MODE_IDENT: begin
        if (c_ident) begin
          hits_next = ibt_pkg::kw_match(hits, plen, in_byte);
          plen_next = ibt_pkg::sat16_inc(plen);
          pos_next  = pos_inc;
        end
      end
      ibt_pkg::MODE_NUMBER: begin
        if (c_digit) begin
          plen_next = ibt_pkg::sat16_inc(plen);
          pos_next  = pos_inc;
        end
      end
      ibt_pkg::MODE_SLASH: begin
        if (!go_idle) begin
          mode_next = ibt_pkg::MODE_COMMENT;
          pos_next  = pos_inc;
        end
      end
      ibt_pkg::MODE_COMMENT: begin
        if (!go_idle) pos_next = pos_inc;
      end
      default: ;
    endcase
    if (go_idle) begin
      mode_next = ibt_pkg::MODE_IDLE;
      if (in_byte == ibt_pkg::CH_NUL) begin
        pos_next    = 16'd0;
        pstart_next = 16'd0;
        plen_next   = 16'd0;
        line_next   = 16'd1;
        hits_next   = 5'h1F;
      end else if (c_blank) begin
        pos_next = pos_inc;
      end else if (in_byte == ibt_pkg::CH_NL) begin
        line_next = ibt_pkg::sat16_inc(line);
        pos_next  = pos_inc;
      end else if (in_byte == ibt_pkg::CH_SLASH) begin
        mode_next   = ibt_pkg::MODE_SLASH;
        pstart_next = pos;
        pos_next    = pos_inc;
      end else if (c_alpha || in_byte == ibt_pkg::CH_UNDER) begin
        mode_next   = ibt_pkg::MODE_IDENT;
        pstart_next = pos;
        hits_next   = ibt_pkg::kw_match(5'h1F, 16'd0, in_byte);
        plen_next   = 16'd1;
        pos_next    = pos_inc;
      end else if (c_digit) begin
        mode_next   = ibt_pkg::MODE_NUMBER;
        pstart_next = pos;
        plen_next   = 16'd1;
        pos_next    = pos_inc;
      end else begin
        pos_next = pos_inc;
      end
    end
  end

  // tokens: one closing the open token, one started by the byte itself
  logic           close_vld, own_vld;
  ibt_pkg::token_t close_tok, own_tok;

  always_comb begin
    close_vld        = 1'b0;
    close_tok.kind   = ibt_pkg::KIND_ERROR;
    close_tok.offset = pstart;
    close_tok.length = plen;
    close_tok.line   = line;
    close_tok.last   = 1'b0;
    unique case (mode)
      ibt_pkg::MODE_IDENT: begin
        close_vld      = go_idle;
        close_tok.kind = ibt_pkg::ident_kind(hits, plen);
      end
      ibt_pkg::MODE_NUMBER: begin
        close_vld      = go_idle;
        close_tok.kind = ibt_pkg::KIND_NUMBER;
      end
      ibt_pkg::MODE_SLASH: begin
        close_vld        = go_idle;
        close_tok.length = 16'd1;
      end
      default: ;
    endcase

    own_tok.offset = pos;
    own_tok.line   = line;
    own_tok.last   = 1'b1;
    if (in_byte == ibt_pkg::CH_NUL) begin
      own_vld        = go_idle;
      own_tok.kind   = ibt_pkg::KIND_EOF;
      own_tok.length = 16'd0;
    end else begin
      own_vld = go_idle && !c_blank && in_byte != ibt_pkg::CH_NL &&
                in_byte != ibt_pkg::CH_SLASH && !c_ident;
      own_tok.kind   = ibt_pkg::punct_kind(in_byte);
      own_tok.length = 16'd1;
    end

    step.count = {1'b0, close_vld} + {1'b0, own_vld};
    step.tok1  = own_tok;
    if (close_vld) begin
      step.tok0      = close_tok;
      step.tok0.last = !own_vld;
    end else begin
      step.tok0 = own_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= ibt_pkg::MODE_IDLE;
      pos    <= 16'd0;
      pstart <= 16'd0;
      plen   <= 16'd0;
      line   <= 16'd1;
      hits   <= 5'h1F;
    end else if (in_fire) begin
      mode   <= mode_next;
      pos    <= pos_next;
      pstart <= pstart_next;
      plen   <= plen_next;
      line   <= line_next;
      hits   <= hits_next;
    end
  end

endmodule

@@ sv/ibt_token_fifo.sv @@
// Four-entry token queue: takes up to two tokens a cycle, gives one.
// Depends on ibt_pkg.
module ibt_token_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  ibt_pkg::step_t   wr_step,
  output logic             room,
  input  logic             rd_en,
  output logic             rd_valid,
  output ibt_pkg::token_t  rd_tok
);

  ibt_pkg::token_t mem [ibt_pkg::FIFO_DEPTH];
  logic [ibt_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [ibt_pkg::FIFO_AW:0]   count;
  logic [1:0]                  wr_n;
  logic                        rd_do;

  localparam logic [ibt_pkg::FIFO_AW:0] ROOM_MAX = (ibt_pkg::FIFO_AW + 1)'(ibt_pkg::FIFO_DEPTH - 2);

  assign room     = count <= ROOM_MAX;
  assign rd_valid = count != '0;
  assign rd_tok   = mem[rd_ptr];
  assign rd_do    = rd_en && rd_valid;
  assign wr_n     = wr_en ? wr_step.count : 2'd0;

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) mem[wr_ptr] <= wr_step.tok0;
    if (wr_n == 2'd2) mem[wr_ptr + 1'b1] <= wr_step.tok1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ibt_pkg::FIFO_AW'(wr_n);
      rd_ptr <= rd_ptr + ibt_pkg::FIFO_AW'(rd_do);
      count  <= count + (ibt_pkg::FIFO_AW + 1)'(wr_n) - (ibt_pkg::FIFO_AW + 1)'(rd_do);
    end
  end

endmodule

@@ sv/ibt_checker.sv @@
// Port-level checks of the byte tokenizer, bound to the top level.
// Depends on ibt_pkg and idl_byte_tokenizer_core_defines.svh.
`include "idl_byte_tokenizer_core_defines.svh"

module ibt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast
);

  logic [3:0]  kind;
  logic [15:0] len;

  assign kind = m_tdata[3:0];
  assign len  = m_tdata[35:20];

  `IBT_ASSERT(a_stall_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled token changed")
  `IBT_ASSERT(a_eof_shape, clk, rst, m_tvalid && kind == ibt_pkg::KIND_EOF |-> len == 16'd0 && m_tlast, "eof token not empty or not last")
  `IBT_ASSERT(a_single_len, clk, rst, m_tvalid && kind >= ibt_pkg::KIND_ERROR |-> len == 16'd1, "single-char token length wrong")
  `IBT_ASSERT(a_eof_out, clk, rst, s_tvalid && s_tready && s_tdata == ibt_pkg::CH_NUL |=> m_tvalid, "end byte gave no token")
  `IBT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "token offered right after reset")

endmodule

bind idl_byte_tokenizer_core ibt_checker u_ibt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
